// ===== design/mseu_pkg.sv =====
// Package: types and constants for the multi-stack execute unit.
`default_nettype none
package mseu_pkg;
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int STACK_COUNT_DEF = 27;
   localparam int TEXT_STACK_DEF  = 0;

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0, OP_MOVE = 4'd1, OP_ADDI = 4'd2, OP_ADDS = 4'd3,
      OP_SUBI = 4'd4, OP_SUBS = 4'd5, OP_ZCLR = 4'd6, OP_POP  = 4'd7,
      OP_QUERY = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDB, ST_RDA, ST_CALC, ST_CONV, ST_WRITE, ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== design/mseu_if.sv =====
// Interfaces: request and response channels.
`default_nettype none
interface mseu_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         req_type;
   logic [4:0]         stack_a;
   logic [4:0]         stack_b;
   logic signed [31:0] immediate;
   modport source (output valid, req_type, stack_a, stack_b, immediate, input ready);
   modport sink   (input valid, req_type, stack_a, stack_b, immediate, output ready);
endinterface

interface mseu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               target_empty;
   logic               overflow_flag;
   modport source (output valid, result_value, target_empty, overflow_flag, input ready);
   modport sink   (input valid, result_value, target_empty, overflow_flag, output ready);
endinterface
`default_nettype wire

// ===== design/multi_stack_execute_unit.sv =====
// Flow: query, unused codes and out-of-range stacks go from IDLE straight to DONE; other
//   ops pass RDA and CALC, and ops with a stack b pass RDB first; a text-stack push adds
//   CONV once per decimal digit (up to 10) and WRITE once per written character (one when dropped).
// Throughput: one request at a time; ready returns the cycle after the response is taken.
// Reset: synchronous, clears heights and control; the stack memory is not cleared
//   (entries above a stack's height are never read).
`default_nettype none
module multi_stack_execute_unit import mseu_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int STACK_COUNT = STACK_COUNT_DEF,
   parameter int TEXT_STACK  = TEXT_STACK_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mseu_req_if.sink    req,
   mseu_rsp_if.source  rsp
);
   localparam int DW = $clog2(STACK_DEPTH);     // entry index width
   localparam int HW = $clog2(STACK_DEPTH + 1); // height width
   localparam int SW = $clog2(STACK_COUNT);
   localparam int AW = SW + DW;

   // Stack storage: one word per entry, row per stack
   logic [31:0] mem [STACK_COUNT*(2**DW)];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_data;

   logic [HW-1:0] height_ff [STACK_COUNT];

   state_type state_ff, state_in;
   op_type    op_ff;
   logic [SW-1:0] a_ff, b_ff;
   logic [31:0]   imm_ff, bval_ff, val_ff;
   logic          bada_ff;
   logic          aempty_ff;   // stack a empty when its top was read
   // decimal conversion
   logic [31:0]   mag_ff;
   logic [3:0]    dig_ff [10];
   logic [3:0]    nd_ff, wk_ff;
   logic          neg_ff;
   logic [3:0]    nch;
   logic [31:0]   calc_val;

   logic [31:0] rsp_val_ff;
   logic        rsp_emp_ff, rsp_ovf_ff, rsp_valid_ff;

   wire logic is_b_op = (req.req_type == OP_MOVE) || (req.req_type == OP_ADDS) ||
                        (req.req_type == OP_SUBS);
   wire logic accept = req.valid && req.ready;
   wire logic a_bad  = 32'(req.stack_a) >= STACK_COUNT;
   wire logic b_bad  = is_b_op && (32'(req.stack_b) >= STACK_COUNT);

   wire logic [HW-1:0] ha = height_ff[a_ff];
   wire logic [HW-1:0] hb = height_ff[b_ff];
   wire logic a_text  = 32'(a_ff) == TEXT_STACK;
   wire logic pushes  = (op_ff == OP_PUSH) || (op_ff == OP_MOVE) || (op_ff == OP_ADDI) ||
                        (op_ff == OP_ADDS) || (op_ff == OP_SUBI) || (op_ff == OP_SUBS);
   wire logic [31:0] topa = aempty_ff ? 32'd0 : rd_data_ff;
   // height of a at push time; a b pop with a == b is already applied
   wire logic [HW-1:0] ha_eff = ha;
   assign nch = nd_ff + {3'd0, neg_ff};
   wire logic fits = a_text ? (32'(ha_eff) + 32'(nch) <= STACK_DEPTH)
                            : (32'(ha_eff) < STACK_DEPTH);
   // constant divide by ten, reciprocal multiply
   wire logic [63:0] mag_prod = {32'd0, mag_ff} * 64'h0000_0000_CCCC_CCCD;
   wire logic [31:0] mag_q = {3'd0, mag_prod[63:35]};
   wire logic [3:0]  mag_r = 4'(mag_ff - {mag_q[28:0], 3'd0} - {mag_q[30:0], 1'b0});

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) begin
            if (a_bad || b_bad || req.req_type > OP_QUERY || req.req_type == OP_QUERY)
               state_in = ST_DONE;
            else if (is_b_op) state_in = ST_RDB;
            else state_in = ST_RDA;
         end
         ST_RDB:   state_in = ST_RDA;
         ST_RDA:   state_in = ST_CALC;
         ST_CALC:  state_in = (pushes && a_text) ? ST_CONV : ST_DONE;
         ST_CONV:  if (mag_q == 0 || nd_ff == 4'd9) state_in = ST_WRITE;
         ST_WRITE: if (!fits || wk_ff + 4'd1 >= nch) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory access selection
   always_comb begin
      rd_addr = {a_ff, DW'(ha - 1'b1)};
      if (state_ff == ST_RDB) rd_addr = {b_ff, DW'(hb - 1'b1)};
      wr_en   = 1'b0;
      wr_addr = {a_ff, DW'(ha_eff)};
      wr_data = val_ff;
      unique case (state_ff)
         ST_CALC: begin
            wr_en   = pushes && !a_text && fits;
            wr_data = calc_val;
         end
         ST_WRITE: begin
            wr_en   = fits;
            wr_addr = {a_ff, DW'(ha_eff + HW'(wk_ff))};
            if (neg_ff && wk_ff == 0) wr_data = 32'd45;
            else wr_data = 32'd48 + 32'(dig_ff[4'(nd_ff - (wk_ff - 4'(neg_ff)) - 4'd1)]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // operation value computed at CALC
   always_comb begin
      unique case (op_ff)
         OP_PUSH: calc_val = imm_ff;
         OP_MOVE: calc_val = bval_ff;
         OP_ADDI: calc_val = topa + imm_ff;
         OP_ADDS: calc_val = topa + bval_ff;
         OP_SUBI: calc_val = topa - imm_ff;
         OP_SUBS: calc_val = topa - bval_ff;
         OP_ZCLR: calc_val = topa;
         OP_POP:  calc_val = topa;
         default: calc_val = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STACK_COUNT; i++) height_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               op_ff      <= op_type'(req.req_type);
               a_ff       <= SW'(req.stack_a);
               b_ff       <= SW'(req.stack_b);
               imm_ff     <= req.immediate;
               bval_ff    <= 32'd0;
               rsp_ovf_ff <= 1'b0;
               rsp_val_ff <= 32'd0;
               bada_ff    <= a_bad;
               rsp_emp_ff <= 1'b1;
            end
            ST_RDB: ;
            ST_RDA: begin
               aempty_ff <= (ha == '0);
               // b top is available now; pop b
               if (op_ff == OP_MOVE || op_ff == OP_ADDS || op_ff == OP_SUBS) begin
                  if (hb != '0) begin
                     bval_ff      <= rd_data_ff;
                     height_ff[b_ff] <= hb - 1'b1;
                  end
               end
            end
            ST_CALC: begin
               val_ff     <= calc_val;
               rsp_val_ff <= calc_val;
               neg_ff     <= calc_val[31];
               mag_ff     <= calc_val[31] ? 32'd0 - calc_val : calc_val;
               nd_ff      <= 4'd0;
               wk_ff      <= 4'd0;
               if (pushes && !a_text) begin
                  if (fits) height_ff[a_ff] <= ha_eff + 1'b1;
                  else rsp_ovf_ff <= 1'b1;
               end
               if (op_ff == OP_ZCLR && calc_val == 0) height_ff[a_ff] <= '0;
               if (op_ff == OP_POP && ha != '0) height_ff[a_ff] <= ha - 1'b1;
            end
            ST_CONV: begin
               dig_ff[nd_ff] <= mag_r;
               mag_ff        <= mag_q;
               nd_ff         <= nd_ff + 4'd1;
            end
            ST_WRITE: begin
               wk_ff <= wk_ff + 4'd1;
               if (!fits) rsp_ovf_ff <= 1'b1;
               else if (wk_ff + 4'd1 >= nch) height_ff[a_ff] <= ha_eff + HW'(nch);
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               if (!bada_ff) rsp_emp_ff <= height_ff[a_ff] == '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_value  = rsp_val_ff;
   assign rsp.target_empty  = rsp_emp_ff;
   assign rsp.overflow_flag = rsp_ovf_ff;

   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   ap_one_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready) else $error("second request accepted");
   ap_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE) else $error("stray response");
endmodule
`default_nettype wire
